@@ rtl/core/bst_pkg.sv @@
// Shared constants, operation codes and control structs for the bounded set table.
package bst_pkg;

   localparam int DEF_CAPACITY  = 16;
   localparam int DEF_ELEM_BITS = 32;

   localparam int OP_W       = 2;
   localparam int ELEMENT_W  = 32;
   localparam int COUNT_W    = 5;
   localparam int RSP_DATA_W = 8;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic scan;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic out_ready;
   } status_type;

endpackage

@@ rtl/core/bounded_set_table_top.sv @@
// Each item passes through accept, a scan that reads every slot key in turn through the
// single read port of the key memory, a drain of the compare, and an update that waits
// until the output register can take the result. The next item is accepted while a
// finished result still waits in the output register. Synchronous active-high reset empties
// the set at once by clearing all valid bits and the count; the key memory is not cleared.
module bounded_set_table_top #(
   parameter int CAPACITY  = bst_pkg::DEF_CAPACITY,
   parameter int ELEM_BITS = bst_pkg::DEF_ELEM_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bst_pkg::ELEMENT_W-1:0]      req_tdata,   // [31:0] element
   input  logic [bst_pkg::OP_W-1:0]           req_tuser,   // [1:0] operation
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] was_member, [1] changed, [2] full_refused, [7:3] count
   output logic [bst_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import bst_pkg::*;

   cmd_type             cmd;
   status_type          status;
   logic                was_member;
   logic                changed;
   logic                full_refused;
   logic [COUNT_W-1:0]  count;

   bst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bst_datapath #(
      .CAPACITY  (CAPACITY),
      .ELEM_BITS (ELEM_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_tuser),
      .req_element      (req_tdata),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_was_member   (was_member),
      .rsp_changed      (changed),
      .rsp_full_refused (full_refused),
      .rsp_count        (count)
   );

   assign rsp_tdata = {count, full_refused, changed, was_member};

endmodule

@@ rtl/core/bst_ctrl.sv @@
// Controller state machine that sequences accept, slot scan and result update.
module bst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  bst_pkg::status_type status,
   output bst_pkg::cmd_type    cmd
);
   import bst_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold here until the output register can take the result.
            if (status.out_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign cmd.start  = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.finish = (state_ff == ST_FINISH) && status.out_ready;

endmodule

@@ rtl/core/bst_datapath.sv @@
// Datapath with the key memory, valid bits, element count, scan logic and result register.
module bst_datapath #(
   parameter int CAPACITY  = bst_pkg::DEF_CAPACITY,
   parameter int ELEM_BITS = bst_pkg::DEF_ELEM_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bst_pkg::cmd_type                  cmd,
   output bst_pkg::status_type               status,
   input  logic [bst_pkg::OP_W-1:0]          req_operation,
   input  logic [bst_pkg::ELEMENT_W-1:0]     req_element,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic                              rsp_was_member,
   output logic                              rsp_changed,
   output logic                              rsp_full_refused,
   output logic [bst_pkg::COUNT_W-1:0]       rsp_count
);
   import bst_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [ELEM_BITS-1:0] slot_key_ff [CAPACITY];
   logic [ELEM_BITS-1:0] rd_key_ff;
   logic [CAPACITY-1:0]  slot_valid_ff, slot_valid_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic [OP_W-1:0]      op_ff;
   logic [ELEM_BITS-1:0] key_ff;
   logic [IDX_W-1:0]     scan_idx_ff;
   logic [IDX_W-1:0]     cmp_idx_ff;
   logic                 cmp_vld_ff;
   logic                 hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;

   logic                 rsp_tvalid_ff;
   logic                 was_ff, changed_ff, refused_ff;
   logic [COUNT_W-1:0]   count_out_ff;

   logic                 mem_we;
   logic                 changed_in, refused_in;

   assign status.scan_last = (scan_idx_ff == IDX_W'(CAPACITY - 1));
   assign status.out_ready = !rsp_tvalid_ff || rsp_tready;

   // Key memory: one write port for inserts, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (mem_we) slot_key_ff[free_idx_ff] <= key_ff;
      rd_key_ff <= slot_key_ff[scan_idx_ff];
   end

   // Scan pipeline: the compare stage sees the slot that was read in the previous cycle.
   always_comb begin
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (cmp_vld_ff) begin
         if (slot_valid_ff[cmp_idx_ff] && (rd_key_ff == key_ff) && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = cmp_idx_ff;
         end
         if (!slot_valid_ff[cmp_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
      end
   end

   always_comb begin
      slot_valid_in = slot_valid_ff;
      count_in      = count_ff;
      mem_we        = 1'b0;
      changed_in    = 1'b0;
      refused_in    = 1'b0;
      case (op_ff)
         OP_INSERT: begin
            if (!hit_found_ff) begin
               if (free_found_ff) begin
                  mem_we                     = cmd.finish;
                  slot_valid_in[free_idx_ff] = 1'b1;
                  count_in                   = count_ff + CNT_W'(1);
                  changed_in                 = 1'b1;
               end else begin
                  refused_in = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            if (hit_found_ff) begin
               slot_valid_in[hit_idx_ff] = 1'b0;
               if (count_ff != '0) count_in = count_ff - CNT_W'(1);
               changed_in = 1'b1;
            end
         end
         OP_QUERY: begin
         end
         OP_CLEAR: begin
            slot_valid_in = '0;
            count_in      = '0;
            changed_in    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         scan_idx_ff   <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan;
         if (cmd.start) begin
            scan_idx_ff   <= '0;
            hit_found_ff  <= 1'b0;
            free_found_ff <= 1'b0;
         end else begin
            if (cmd.scan) scan_idx_ff <= scan_idx_ff + IDX_W'(1);
            hit_found_ff  <= hit_found_in;
            free_found_ff <= free_found_in;
         end
         if (cmd.finish) begin
            slot_valid_ff <= slot_valid_in;
            count_ff      <= count_in;
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= req_operation;
         key_ff <= ELEM_BITS'(req_element);
      end
      cmp_idx_ff  <= scan_idx_ff;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      if (cmd.finish) begin
         was_ff       <= hit_found_ff;
         changed_ff   <= changed_in;
         refused_ff   <= refused_in;
         count_out_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_tvalid       = rsp_tvalid_ff;
   assign rsp_was_member   = was_ff;
   assign rsp_changed      = changed_ff;
   assign rsp_full_refused = refused_ff;
   assign rsp_count        = count_out_ff;

endmodule

@@ dv/tb_bounded_set_table_top.sv @@
// Self-checking testbench for the bounded set table: directed rows, then random set operations.
`timescale 1ns / 100ps

module tb_bounded_set_table_top;
   import bst_pkg::*;

   localparam int CAPACITY     = DEF_CAPACITY;
   localparam int RANDOM_ITEMS = 500;
   localparam int QUIET_ITEMS  = 100;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 3000;
   localparam int POOL_SIZE    = 24;

   typedef struct packed {
      logic         was_member;
      logic         changed;
      logic         full_refused;
      logic [COUNT_W-1:0] count;
   } set_result_type;

   typedef struct {
      logic [OP_W-1:0]      op;
      logic [ELEMENT_W-1:0] element;
      bit                   typed;
      set_result_type       want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ELEMENT_W-1:0]  req_tdata;   // [31:0] element
   logic [OP_W-1:0]       req_tuser;   // [1:0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [0] was_member, [1] changed, [2] full_refused, [7:3] count

   // Shadow copy of the table.
   bit                   shadow_valid [CAPACITY];
   logic [ELEMENT_W-1:0] shadow_key   [CAPACITY];
   int unsigned          shadow_count;

   set_result_type       pending_results [$];
   stim_row_type         directed_rows [$];
   logic [ELEMENT_W-1:0] key_pool [POOL_SIZE];

   int  failures;
   int  items_sent;
   int  results_seen;
   int  refused_seen;
   int  hits_seen;
   int  clears_sent;
   int  stall_cycles;
   bit  quiet;
   bit  hold_requested;
   bit  hold_done;

   bounded_set_table_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic set_result_type res(bit w, bit c, bit f, int n);
      set_result_type r;
      r.was_member   = w;
      r.changed      = c;
      r.full_refused = f;
      r.count        = n[COUNT_W-1:0];
      return r;
   endfunction

   // Applies one operation to the shadow table and returns what the block should report.
   function automatic set_result_type apply_set_op(logic [OP_W-1:0] op,
                                                   logic [ELEMENT_W-1:0] element);
      set_result_type r;
      int hit;
      int free_slot;
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hit < 0 && shadow_valid[i] && shadow_key[i] == element)
            hit = i;
         if (free_slot < 0 && !shadow_valid[i])
            free_slot = i;
      end
      r = res(hit >= 0, 1'b0, 1'b0, 0);
      case (op)
         OP_INSERT: begin
            if (hit < 0) begin
               if (free_slot >= 0) begin
                  shadow_valid[free_slot] = 1'b1;
                  shadow_key[free_slot]   = element;
                  shadow_count++;
                  r.changed = 1'b1;
               end else begin
                  r.full_refused = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            if (hit >= 0) begin
               shadow_valid[hit] = 1'b0;
               if (shadow_count > 0)
                  shadow_count--;
               r.changed = 1'b1;
            end
         end
         OP_QUERY: ;
         default: begin
            for (int i = 0; i < CAPACITY; i++)
               shadow_valid[i] = 1'b0;
            shadow_count = 0;
            r.changed = 1'b1;
         end
      endcase
      r.count = shadow_count[COUNT_W-1:0];
      return r;
   endfunction

   // Offers one item and holds it until the block takes it; the expectation is queued then.
   task automatic offer_item(input logic [OP_W-1:0] op, input logic [ELEMENT_W-1:0] element,
                             input bit typed, input set_result_type want);
      set_result_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= element;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = apply_set_op(op, element);
      pending_results.push_back(typed ? want : predicted);
      items_sent++;
      if (op == OP_CLEAR)
         clears_sent++;
   endtask

   task automatic sender_gap(input bit gappy);
      if (!quiet && gappy && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   function automatic logic [OP_W-1:0] pick_op(int phase);
      int roll;
      roll = $urandom_range(0, 99);
      case (phase)
         0:       return roll < 60 ? OP_INSERT : roll < 75 ? OP_REMOVE :
                         roll < 97 ? OP_QUERY : OP_CLEAR;
         2:       return roll < 25 ? OP_INSERT : roll < 65 ? OP_REMOVE :
                         roll < 96 ? OP_QUERY : OP_CLEAR;
         default: return roll < 45 ? OP_INSERT : roll < 70 ? OP_REMOVE :
                         roll < 97 ? OP_QUERY : OP_CLEAR;
      endcase
   endfunction

   initial begin : main
      logic [ELEMENT_W-1:0] fill_key;
      logic [OP_W-1:0]      op;
      logic [ELEMENT_W-1:0] element;
      bit                   gappy;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_QUERY;
      rsp_tready = 1'b0;
      shadow_count = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_key[i]   = '0;
      end

      directed_rows.push_back('{OP_QUERY,  32'h0000_0000, 1, res(0, 0, 0, 0)});
      directed_rows.push_back('{OP_REMOVE, 32'hFFFF_FFFF, 1, res(0, 0, 0, 0)});
      directed_rows.push_back('{OP_INSERT, 32'h0000_0000, 1, res(0, 1, 0, 1)});
      directed_rows.push_back('{OP_INSERT, 32'hFFFF_FFFF, 1, res(0, 1, 0, 2)});
      directed_rows.push_back('{OP_INSERT, 32'h0000_0000, 1, res(1, 0, 0, 2)});
      directed_rows.push_back('{OP_QUERY,  32'hFFFF_FFFF, 1, res(1, 0, 0, 2)});
      directed_rows.push_back('{OP_QUERY,  32'h8000_0000, 1, res(0, 0, 0, 2)});
      directed_rows.push_back('{OP_REMOVE, 32'h0000_0000, 1, res(1, 1, 0, 1)});
      directed_rows.push_back('{OP_REMOVE, 32'h0000_0000, 1, res(0, 0, 0, 1)});
      directed_rows.push_back('{OP_CLEAR,  32'hFFFF_FFFF, 1, res(1, 1, 0, 0)});
      directed_rows.push_back('{OP_CLEAR,  32'h0000_0000, 1, res(0, 1, 0, 0)});
      // Fill every slot with alternating one-hot and one-cold keys.
      for (int i = 0; i < CAPACITY; i++) begin
         fill_key = 32'h1 << (2 * i);
         if (i % 2)
            fill_key = ~fill_key;
         directed_rows.push_back('{OP_INSERT, fill_key, 0, res(0, 0, 0, 0)});
      end
      directed_rows.push_back('{OP_INSERT, 32'h5A5A_5A5A, 1, res(0, 0, 1, 16)});
      directed_rows.push_back('{OP_INSERT, 32'h0000_0001, 1, res(1, 0, 0, 16)});
      // Free a middle slot, then the refused key should fit into it.
      directed_rows.push_back('{OP_REMOVE, 32'h0000_0100, 0, res(0, 0, 0, 0)});
      directed_rows.push_back('{OP_INSERT, 32'h5A5A_5A5A, 0, res(0, 0, 0, 0)});
      directed_rows.push_back('{OP_QUERY,  32'h5A5A_5A5A, 0, res(0, 0, 0, 0)});
      directed_rows.push_back('{OP_CLEAR,  32'h1234_5678, 1, res(0, 1, 0, 0)});

      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gappy = 1'b1;
      foreach (directed_rows[i]) begin
         offer_item(directed_rows[i].op, directed_rows[i].element,
                    directed_rows[i].typed, directed_rows[i].want);
         sender_gap(gappy);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0)
            gappy = $urandom_range(0, 1);
         if (n == RANDOM_ITEMS - QUIET_ITEMS)
            quiet = 1'b1;
         if (n == 200)
            hold_requested = 1'b1;
         op = pick_op(n / 100);
         if ($urandom_range(0, 4) == 0)
            element = $urandom;
         else
            element = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         offer_item(op, element, 0, res(0, 0, 0, 0));
         sender_gap(gappy);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);

      $display("Sent %0d items (%0d directed) with %0d clears; %0d results, %0d hits, %0d refused.",
               items_sent, directed_rows.size(), clears_sent, results_seen, hits_seen,
               refused_seen);
      if (failures == 0)
         $display("tb_bounded_set_table_top passed");
      else
         $display("tb_bounded_set_table_top failed");
      $finish;
   end

   // Receiver: random stall bursts, one long hold-off so the block backs up into its input.
   initial begin : receiver
      wait (reset === 1'b0);
      forever begin
         if (hold_requested && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : result_check
      set_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tdata[0])
            hits_seen++;
         if (rsp_tdata[2])
            refused_seen++;
         if (pending_results.size() == 0) begin
            $error("result 0x%02h arrived with no item outstanding", rsp_tdata);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[0] !== want.was_member) begin
               $error("was_member: expected %0d, got %0d", want.was_member, rsp_tdata[0]);
               failures++;
            end
            if (rsp_tdata[1] !== want.changed) begin
               $error("changed: expected %0d, got %0d", want.changed, rsp_tdata[1]);
               failures++;
            end
            if (rsp_tdata[2] !== want.full_refused) begin
               $error("full_refused: expected %0d, got %0d", want.full_refused, rsp_tdata[2]);
               failures++;
            end
            if (rsp_tdata[7:3] !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_tdata[7:3]);
               failures++;
            end
         end
      end
   end

   // Ends a hung run: counts cycles in which neither channel moves an item.
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_bounded_set_table_top failed");
         $finish;
      end
   end

endmodule
